// File: src/mts_pkg.sv
// Shared types, constants and lookup functions of the MML tone sequencer.
package mts_pkg;

  localparam int LYRIC_MAX_DEF = 30;
  localparam int NUM_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [7:0] WHOLE_NOTE     = 8'd192;
  localparam logic [6:0] TICKS_PER_UNIT = 7'd125;
  localparam logic [4:0] TOP_OCT_SHIFT  = 5'd17;
  localparam logic [3:0] OCT_MAX        = 4'd15;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SYNTAX = 2'd1;
  localparam logic [1:0] ERR_ZERO   = 2'd2;
  localparam logic [1:0] ERR_LYRIC  = 2'd3;

  // One unit of work handed from the parser to the tone generator.
  typedef struct packed {
    logic        has_note;
    logic [7:0]  pitch;
    logic        is_rest;
    logic [15:0] length;
    logic [15:0] tempo;
    logic [2:0]  gate;
    logic        gated;
    logic [1:0]  err;
  } job_t;

  // Top-octave frequencies in millihertz.
  function automatic logic [30:0] tone_top(input logic [3:0] idx);
    logic [30:0] r;
    case (idx)
      4'd0:    r = 31'd1071618315;
      4'd1:    r = 31'd1135340056;
      4'd2:    r = 31'd1202850889;
      4'd3:    r = 31'd1274376125;
      4'd4:    r = 31'd1350154473;
      4'd5:    r = 31'd1430438836;
      4'd6:    r = 31'd1515497155;
      4'd7:    r = 31'd1605613306;
      4'd8:    r = 31'd1701088041;
      4'd9:    r = 31'd1802240000;
      4'd10:   r = 31'd1909406767;
      4'd11:   r = 31'd2022946002;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

  // Semitone offset of the letters A to G.
  function automatic logic [3:0] step_of(input logic [2:0] letter);
    logic [3:0] r;
    case (letter)
      3'd0:    r = 4'd9;
      3'd1:    r = 4'd11;
      3'd2:    r = 4'd0;
      3'd3:    r = 4'd2;
      3'd4:    r = 4'd4;
      3'd5:    r = 4'd5;
      3'd6:    r = 4'd7;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Adds half the length for a dot, saturating.
  function automatic logic [15:0] dotted(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + {2'b00, v[15:1]};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

// File: src/mts_queue.sv
// Short job queue between the parser and the tone generator.
module mts_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mts_pkg::job_t push_job,
  input  logic          pop,
  output mts_pkg::job_t head,
  output logic          empty,
  output logic          full
);
  import mts_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop) count <= count + (PW+1)'(1);
      else if (pop && !push) count <= count - (PW+1)'(1);
    end
  end

endmodule

// File: src/mts_front.sv
// Text parser: takes one MML byte per beat and turns finished notes and errors into jobs.
module mts_front #(
  parameter int LYRIC_MAX = mts_pkg::LYRIC_MAX_DEF,
  parameter int NUM_BITS  = mts_pkg::NUM_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    text_byte,
  input  logic          text_valid,
  output logic          text_ready,
  input  logic          queue_full,
  output logic          push,
  output mts_pkg::job_t job
);
  import mts_pkg::*;

  localparam int LC_W = $clog2(LYRIC_MAX + 2);
  localparam logic [NUM_BITS-1:0] NUM_MAX = '1;

  localparam logic [3:0] M_TOP       = 4'd0;
  localparam logic [3:0] M_NOTE_ACC  = 4'd1;
  localparam logic [3:0] M_NOTE_LEN  = 4'd2;
  localparam logic [3:0] M_NOTE_NUM  = 4'd3;
  localparam logic [3:0] M_NOTE_DOTS = 4'd4;
  localparam logic [3:0] M_NUM_O     = 4'd5;
  localparam logic [3:0] M_NUM_Q     = 4'd6;
  localparam logic [3:0] M_NUM_L     = 4'd7;
  localparam logic [3:0] M_L_DOTS    = 4'd8;
  localparam logic [3:0] M_NUM_T     = 4'd9;
  localparam logic [3:0] M_DOLLAR    = 4'd10;
  localparam logic [3:0] M_SKIP      = 4'd11;
  localparam logic [3:0] M_K_SEEK    = 4'd12;
  localparam logic [3:0] M_LYRIC     = 4'd13;
  localparam logic [3:0] M_LYRIC_ESC = 4'd14;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_T     = 8'h54;

  logic [3:0]          mode, mode_next;
  logic [3:0]          octave, octave_next;
  logic [15:0]         dlen, dlen_next;
  logic [15:0]         gate, gate_next;
  logic [15:0]         tempo, tempo_next;
  logic [NUM_BITS-1:0] acc, acc_next;
  logic [7:0]          ppitch, ppitch_next;
  logic                prest, prest_next;
  logic [15:0]         plen, plen_next;
  logic [LC_W-1:0]     lcount, lcount_next;
  logic                halted, halted_next;

  // Divider for 192 / number, one quotient bit a cycle.
  logic [7:0]          held;
  logic                busy;
  logic [3:0]          div_cnt;
  logic [7:0]          div_dvd;
  logic [7:0]          div_q;
  logic [NUM_BITS-1:0] div_rem;
  logic [NUM_BITS:0]   div_t;
  logic                div_bit;
  logic                div_done;

  logic                accept, needs_div, proc;
  logic [7:0]          c;
  logic                digit;
  logic [NUM_BITS+3:0] acc_wide;
  logic [NUM_BITS-1:0] acc_inc;
  logic [23:0]         acc24;
  logic [15:0]         acc_sat;
  logic [15:0]         q16;
  logic [7:0]          oct12;
  logic [LC_W-1:0]     lcount_inc;
  logic                do_top, do_end, j_note, j_gated;
  logic [15:0]         j_len;
  logic [1:0]          fail;

  assign text_ready = !busy && !queue_full;
  assign accept     = text_valid && text_ready;
  assign div_done   = busy && (div_cnt == 4'd8);
  assign needs_div  = !halted && ((mode == M_NOTE_NUM) || (mode == M_NUM_L))
                      && !((text_byte >= CH_0) && (text_byte <= CH_9)) && (acc != '0);
  assign proc       = (accept && !needs_div && !halted) || div_done;
  assign c          = div_done ? held : text_byte;

  assign div_t   = {div_rem, div_dvd[7]};
  assign div_bit = (div_t >= {1'b0, acc});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && needs_div) begin
      busy    <= 1'b1;
      held    <= text_byte;
      div_cnt <= 4'd0;
      div_dvd <= WHOLE_NOTE;
      div_rem <= '0;
      div_q   <= '0;
    end else if (div_done) begin
      busy <= 1'b0;
    end else if (busy) begin
      div_cnt <= div_cnt + 4'd1;
      div_dvd <= {div_dvd[6:0], 1'b0};
      div_rem <= div_bit ? NUM_BITS'(div_t - {1'b0, acc}) : div_t[NUM_BITS-1:0];
      div_q   <= {div_q[6:0], div_bit};
    end
  end

  always_comb begin
    mode_next   = mode;
    octave_next = octave;
    dlen_next   = dlen;
    gate_next   = gate;
    tempo_next  = tempo;
    acc_next    = acc;
    ppitch_next = ppitch;
    prest_next  = prest;
    plen_next   = plen;
    lcount_next = lcount;
    halted_next = halted;
    do_top      = 1'b0;
    do_end      = 1'b0;
    j_note      = 1'b0;
    j_gated     = 1'b0;
    j_len       = plen;
    fail        = ERR_NONE;
    digit       = (c >= CH_0) && (c <= CH_9);
    acc_wide    = {acc, 3'b000} + {2'b00, acc, 1'b0} + (NUM_BITS+4)'(c[3:0]);
    acc_inc     = (acc_wide > (NUM_BITS+4)'(NUM_MAX)) ? NUM_MAX : acc_wide[NUM_BITS-1:0];
    acc24       = 24'(acc);
    acc_sat     = (|acc24[23:16]) ? 16'hFFFF : acc24[15:0];
    q16         = {8'd0, div_q};
    lcount_inc  = lcount + LC_W'(1);
    oct12       = 8'd0;

    if (proc) begin
      unique case (mode)
        M_TOP: do_top = 1'b1;
        M_NOTE_ACC, M_NOTE_LEN: begin
          if ((mode == M_NOTE_ACC) && (c == CH_PLUS || c == CH_HASH || c == CH_MINUS)) begin
            if (!prest) ppitch_next = (c == CH_MINUS) ? ppitch - 8'd1 : ppitch + 8'd1;
            mode_next = M_NOTE_LEN;
          end else if (digit) begin
            acc_next  = NUM_BITS'(c[3:0]);
            mode_next = M_NOTE_NUM;
          end else if (c == CH_DOT) begin
            plen_next = dotted(plen);
            mode_next = M_NOTE_DOTS;
          end else begin
            do_end = 1'b1;
          end
        end
        M_NOTE_NUM: begin
          if (digit) acc_next = acc_inc;
          else if (acc == '0) fail = ERR_ZERO;
          else if (c == CH_DOT) begin
            plen_next = dotted(q16);
            mode_next = M_NOTE_DOTS;
          end else begin
            plen_next = q16;
            do_end    = 1'b1;
          end
        end
        M_NOTE_DOTS: begin
          if (c == CH_DOT) plen_next = dotted(plen);
          else do_end = 1'b1;
        end
        M_NUM_O, M_NUM_Q, M_NUM_T: begin
          if (digit) acc_next = acc_inc;
          else begin
            if (mode == M_NUM_O) octave_next = (acc24 > 24'(OCT_MAX)) ? OCT_MAX : acc24[3:0];
            else if (mode == M_NUM_Q) gate_next = acc_sat;
            else tempo_next = acc_sat;
            do_top = 1'b1;
          end
        end
        M_NUM_L: begin
          if (digit) acc_next = acc_inc;
          else if (acc == '0) fail = ERR_ZERO;
          else if (c == CH_DOT) begin
            dlen_next = dotted(q16);
            mode_next = M_L_DOTS;
          end else begin
            dlen_next = q16;
            do_top    = 1'b1;
          end
        end
        M_L_DOTS: begin
          if (c == CH_DOT) dlen_next = dotted(dlen);
          else do_top = 1'b1;
        end
        M_DOLLAR, M_SKIP: begin
          if ((mode == M_DOLLAR) && (c == CH_K)) mode_next = M_K_SEEK;
          else begin
            mode_next = (c == CH_SEMI) ? M_TOP : M_SKIP;
            if (c == CH_NUL) fail = ERR_SYNTAX;
          end
        end
        M_K_SEEK: begin
          if (c == CH_QUOTE) begin
            lcount_next = '0;
            mode_next   = M_LYRIC;
          end else if (c == CH_NUL) fail = ERR_SYNTAX;
        end
        M_LYRIC: begin
          if (c == CH_NUL) fail = ERR_SYNTAX;
          else if (c == CH_QUOTE) mode_next = M_SKIP;
          else begin
            if (c == CH_PCT) mode_next = M_LYRIC_ESC;
            lcount_next = lcount_inc;
            if (lcount_inc > LC_W'(LYRIC_MAX)) fail = ERR_LYRIC;
          end
        end
        M_LYRIC_ESC: begin
          if (c == CH_NUL) fail = ERR_SYNTAX;
          else mode_next = M_LYRIC;
        end
        default: do_top = 1'b1;
      endcase

      // A note or rest ends here; a tie suppresses the gap and the next command.
      if (do_end) begin
        mode_next = M_TOP;
        j_len     = plen_next;
        if (tempo == 16'd0) fail = ERR_ZERO;
        else begin
          j_note  = 1'b1;
          j_gated = !prest && (gate < 16'd8) && (c != CH_AMP);
          do_top  = (c != CH_AMP);
        end
      end

      if (do_top) begin
        mode_next = M_TOP;
        oct12 = 8'({octave_next, 3'b000}) + 8'({octave_next, 2'b00});
        if (((c >= CH_A) && (c <= CH_G)) || (c == CH_R)) begin
          prest_next  = (c == CH_R);
          ppitch_next = (c == CH_R) ? 8'd0
                        : oct12 + {4'd0, step_of(c[2:0] - 3'd1)} + 8'd12;
          plen_next   = dlen_next;
          mode_next   = M_NOTE_ACC;
        end else if (c == CH_LT) begin
          if (octave_next != 4'd0) octave_next = octave_next - 4'd1;
        end else if (c == CH_GT) begin
          if (octave_next != OCT_MAX) octave_next = octave_next + 4'd1;
        end else if (c == CH_O || c == CH_Q || c == CH_L || c == CH_T) begin
          acc_next  = '0;
          mode_next = (c == CH_O) ? M_NUM_O : (c == CH_Q) ? M_NUM_Q
                    : (c == CH_L) ? M_NUM_L : M_NUM_T;
        end else if (c == CH_DOLL) begin
          mode_next = M_DOLLAR;
        end else if (c == CH_NUL) begin
          lcount_next = '0;
        end else begin
          fail = ERR_SYNTAX;
        end
      end

      if (fail != ERR_NONE) begin
        mode_next   = M_TOP;
        halted_next = 1'b1;
      end
    end
  end

  assign push         = proc && (j_note || (fail != ERR_NONE));
  assign job.has_note = j_note;
  assign job.pitch    = ppitch;
  assign job.is_rest  = prest;
  assign job.length   = j_len;
  assign job.tempo    = tempo;
  assign job.gate     = gate[2:0];
  assign job.gated    = j_gated;
  assign job.err      = fail;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_TOP;
      octave <= 4'd4;
      dlen   <= 16'(WHOLE_NOTE / 4);
      gate   <= 16'd7;
      tempo  <= 16'd120;
      acc    <= '0;
      ppitch <= 8'd0;
      prest  <= 1'b0;
      plen   <= 16'd0;
      lcount <= '0;
      halted <= 1'b0;
    end else begin
      mode   <= mode_next;
      octave <= octave_next;
      dlen   <= dlen_next;
      gate   <= gate_next;
      tempo  <= tempo_next;
      acc    <= acc_next;
      ppitch <= ppitch_next;
      prest  <= prest_next;
      plen   <= plen_next;
      lcount <= lcount_next;
      halted <= halted_next;
    end
  end

endmodule

// File: src/mts_back.sv
// Tone generator: divides out each note job's duration and presents its segments, and any error, as result beats.
module mts_back (
  input  logic          clk,
  input  logic          rst,
  input  mts_pkg::job_t job,
  input  logic          queue_empty,
  output logic          pop,
  output logic [30:0]   tone_mhz,
  output logic [15:0]   duration_ticks,
  output logic [1:0]    error_code,
  output logic          last_of_run,
  output logic          tone_valid,
  input  logic          tone_ready
);
  import mts_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DIV  = 3'd1;
  localparam logic [2:0] B_CALC = 3'd2;
  localparam logic [2:0] B_SEG1 = 3'd3;
  localparam logic [2:0] B_SEG2 = 3'd4;
  localparam logic [2:0] B_ERR  = 3'd5;

  localparam int DW = 23;

  logic [2:0]    state;
  job_t          jb;
  logic [DW-1:0] dvd;
  logic [15:0]   rem;
  logic [4:0]    cnt;
  logic [16:0]   div_t;
  logic          div_bit;
  logic [15:0]   dur;
  logic [30:0]   tone;
  logic [15:0]   oct_prod;
  logic [4:0]    oct;
  logic [7:0]    semi;
  logic [4:0]    shamt;
  logic [18:0]   gprod;
  logic [15:0]   on_ticks;
  logic          load;
  logic          emit;

  assign pop     = (state == B_IDLE) && !queue_empty;
  assign load    = !tone_valid || tone_ready;
  assign emit    = load && ((state == B_SEG1) || (state == B_SEG2) || (state == B_ERR));
  assign div_t   = {rem, dvd[DW-1]};
  assign div_bit = (div_t >= {1'b0, jb.tempo});

  // Pitch split into octave and semitone by a reciprocal of twelve.
  assign oct_prod = 16'(jb.pitch) * 16'd171;
  assign oct      = oct_prod[15:11];
  assign semi     = jb.pitch - 8'({oct, 3'b000}) - 8'({oct, 2'b00});
  assign shamt    = (oct >= TOP_OCT_SHIFT) ? 5'd0 : TOP_OCT_SHIFT - oct;

  assign gprod    = 19'(dur) * 19'(jb.gate);
  assign on_ticks = gprod[18:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      tone_valid <= 1'b0;
    end else begin
      if (emit) tone_valid <= 1'b1;
      else if (tone_ready) tone_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!queue_empty) begin
            jb  <= job;
            rem <= '0;
            cnt <= '0;
            dvd <= DW'(job.length) * DW'(TICKS_PER_UNIT);
            state <= job.has_note ? B_DIV : B_ERR;
          end
        end
        B_DIV: begin
          rem <= div_bit ? 16'(div_t - {1'b0, jb.tempo}) : div_t[15:0];
          dvd <= {dvd[DW-2:0], div_bit};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DW - 1)) state <= B_CALC;
        end
        B_CALC: begin
          dur   <= (|dvd[DW-1:16]) ? 16'hFFFF : dvd[15:0];
          tone  <= jb.is_rest ? 31'd0 : tone_top(semi[3:0]) >> shamt;
          state <= B_SEG1;
        end
        B_SEG1: begin
          if (load) begin
            tone_mhz       <= tone;
            duration_ticks <= jb.gated ? on_ticks : dur;
            error_code     <= ERR_NONE;
            last_of_run    <= !jb.gated && (jb.err == ERR_NONE);
            state <= jb.gated ? B_SEG2 : ((jb.err != ERR_NONE) ? B_ERR : B_IDLE);
          end
        end
        B_SEG2: begin
          if (load) begin
            tone_mhz       <= 31'd0;
            duration_ticks <= dur - on_ticks;
            error_code     <= ERR_NONE;
            last_of_run    <= (jb.err == ERR_NONE);
            state <= (jb.err != ERR_NONE) ? B_ERR : B_IDLE;
          end
        end
        B_ERR: begin
          if (load) begin
            tone_mhz       <= 31'd0;
            duration_ticks <= 16'd0;
            error_code     <= jb.err;
            last_of_run    <= 1'b1;
            state          <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: src/mml_tone_sequencer.sv
// Top level of the MML tone sequencer: parser, job queue and tone generator.
// The block reads upper-case MML text one byte per input beat and produces tone
// segments (frequency in millihertz, duration in centisecond ticks) on its result
// channel. A byte that closes a note length or an L value with a number first runs
// the divider that forms 192 / n; the input is held while it runs or the queue is full.
// For each note or rest the tone generator takes the job from the queue, runs the
// restoring division of length x 125 by the tempo, looks up the pitch and loads the
// first result beat, then loads each further beat; a four-entry job queue lets the
// parser run ahead of it by that many notes. Once an error is found the block
// accepts and discards every further byte until reset.
module mml_tone_sequencer #(
  parameter int LYRIC_MAX = mts_pkg::LYRIC_MAX_DEF,
  parameter int NUM_BITS  = mts_pkg::NUM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  text_byte,
  input  logic        text_valid,
  output logic        text_ready,
  output logic [30:0] tone_mhz,
  output logic [15:0] duration_ticks,
  output logic [1:0]  error_code,
  output logic        last_of_run,
  output logic        tone_valid,
  input  logic        tone_ready
);
  import mts_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push, pop, q_empty, q_full;

  // The parser keeps all musical state and emits one job per finished note or error.
  mts_front #(
    .LYRIC_MAX (LYRIC_MAX),
    .NUM_BITS  (NUM_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .text_byte  (text_byte),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .queue_full (q_full),
    .push       (push),
    .job        (push_job)
  );

  mts_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The generator owns the output register, so a waiting result stalls parsing only once the job queue is full.
  mts_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job            (head_job),
    .queue_empty    (q_empty),
    .pop            (pop),
    .tone_mhz       (tone_mhz),
    .duration_ticks (duration_ticks),
    .error_code     (error_code),
    .last_of_run    (last_of_run),
    .tone_valid     (tone_valid),
    .tone_ready     (tone_ready)
  );

endmodule

// File: src/mts_checker.sv
// Port-level checks of the MML tone sequencer, bound to the top level.
module mts_checker (
  input logic        clk,
  input logic        rst,
  input logic [30:0] tone_mhz,
  input logic [15:0] duration_ticks,
  input logic [1:0]  error_code,
  input logic        last_of_run,
  input logic        tone_valid,
  input logic        tone_ready
);
  import mts_pkg::*;

  // A result beat holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tone_valid && !tone_ready |=> tone_valid && $stable(tone_mhz) && $stable(duration_ticks))
    else $error("result beat changed before it was taken");

  a_reset: assert property (@(posedge clk) rst |=> !tone_valid)
    else $error("result shown straight after reset");

  // An error beat is silent, empty and ends its run.
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    tone_valid && (error_code != ERR_NONE) |->
      (tone_mhz == 31'd0) && (duration_ticks == 16'd0) && last_of_run)
    else $error("malformed error beat");

  // Nothing follows an error once it has been taken.
  a_halt: assert property (@(posedge clk) disable iff (rst)
    tone_valid && tone_ready && (error_code != ERR_NONE) |=> !tone_valid)
    else $error("result after an error");

endmodule

bind mml_tone_sequencer mts_checker u_mts_checker (
  .clk            (clk),
  .rst            (rst),
  .tone_mhz       (tone_mhz),
  .duration_ticks (duration_ticks),
  .error_code     (error_code),
  .last_of_run    (last_of_run),
  .tone_valid     (tone_valid),
  .tone_ready     (tone_ready)
);

// File: dv/tb.sv
// Self-checking testbench for the MML tone sequencer: stimulus, tone predictor and scoreboard.
`timescale 1ns / 100ps

module tb;
  import mts_pkg::*;

  // The watchdog gives up after this many cycles in which neither channel moves a beat.
  localparam int IDLE_LIMIT  = 5000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 300;
  localparam int RAND_ITEMS  = 100;

  // Parser states of the predictor.
  typedef enum logic [3:0] {
    PM_TOP, PM_ACC, PM_LEN, PM_NUM, PM_DOTS, PM_O, PM_Q, PM_L, PM_LDOTS, PM_T,
    PM_DOLLAR, PM_SKIP, PM_KSEEK, PM_LYRIC, PM_ESC
  } parse_e;

  // One expected result beat.
  typedef struct packed {
    logic [30:0] tone;
    logic [15:0] dur;
    logic [1:0]  err;
    logic        last;
  } tone_seg_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  text_byte = 8'd0;
  logic        text_valid = 1'b0;
  logic        text_ready;
  logic [30:0] tone_mhz;
  logic [15:0] duration_ticks;
  logic [1:0]  error_code;
  logic        last_of_run;
  logic        tone_valid;
  logic        tone_ready = 1'b0;

  always #5 clk = ~clk;

  mml_tone_sequencer dut (
    .clk(clk), .rst(rst),
    .text_byte(text_byte), .text_valid(text_valid), .text_ready(text_ready),
    .tone_mhz(tone_mhz), .duration_ticks(duration_ticks), .error_code(error_code),
    .last_of_run(last_of_run), .tone_valid(tone_valid), .tone_ready(tone_ready)
  );

  // Predictor state, a private copy of everything the block remembers between bytes.
  parse_e      pm;
  logic [3:0]  pr_octave;
  logic [15:0] pr_def_len, pr_gate, pr_tempo, pr_acc, pr_len;
  logic [7:0]  pr_pitch;
  logic        pr_rest, pr_halted;
  logic [5:0]  pr_lyric;

  tone_seg_t   expected_tones[$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          tones_seen = 0;
  int          burst_left = 4;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;

  // Top-octave frequencies in millihertz; lower octaves are right shifts of these.
  function automatic logic [30:0] top_freq(input int idx);
    case (idx)
      0:  return 31'd1071618315;
      1:  return 31'd1135340056;
      2:  return 31'd1202850889;
      3:  return 31'd1274376125;
      4:  return 31'd1350154473;
      5:  return 31'd1430438836;
      6:  return 31'd1515497155;
      7:  return 31'd1605613306;
      8:  return 31'd1701088041;
      9:  return 31'd1802240000;
      10: return 31'd1909406767;
      default: return 31'd2022946002;
    endcase
  endfunction

  function automatic int semis(input logic [7:0] c);
    case (c)
      "A": return 9;
      "B": return 11;
      "C": return 0;
      "D": return 2;
      "E": return 4;
      "F": return 5;
      default: return 7;
    endcase
  endfunction

  function automatic logic [15:0] sat16(input int unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] with_dot(input logic [15:0] v);
    return sat16(int'(v) + int'(v) / 2);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void add_tone(input logic [30:0] t, input int unsigned d,
                                   input logic [1:0] e);
    tone_seg_t s;
    s.tone = t;
    s.dur  = d[15:0];
    s.err  = e;
    s.last = 1'b0;
    expected_tones.push_back(s);
  endfunction

  // An error produces one silent beat carrying the code, after which the block goes deaf.
  function automatic void halt_with(input logic [1:0] e);
    add_tone(31'd0, 0, e);
    pr_halted = 1'b1;
    pm = PM_TOP;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    int unsigned v;
    v = int'(pr_acc) * 10 + int'(c - "0");
    pr_acc = sat16(v);
  endfunction

  // Plays the pending note or rest: one segment, or a sounding part and a silence when gated.
  function automatic void play_pending(input bit tied);
    int unsigned d, j, oct;
    logic [30:0] t;
    pm = PM_TOP;
    if (pr_tempo == 16'd0) begin
      halt_with(ERR_ZERO);
      return;
    end
    d = int'(pr_len) * 125;
    d = sat16(d / int'(pr_tempo));
    oct = int'(pr_pitch) / 12;
    if (pr_rest) t = 31'd0;
    else t = top_freq(int'(pr_pitch) % 12) >> ((oct >= 17) ? 0 : 17 - oct);
    if (!pr_rest && pr_gate < 16'd8 && !tied) begin
      j = d * int'(pr_gate) / 8;
      add_tone(t, j, ERR_NONE);
      add_tone(31'd0, d - j, ERR_NONE);
    end else begin
      add_tone(t, d, ERR_NONE);
    end
  endfunction

  function automatic void top_level(input logic [7:0] c);
    pm = PM_TOP;
    if ((c >= "A" && c <= "G") || c == "R") begin
      pr_rest  = (c == "R");
      pr_pitch = pr_rest ? 8'd0 : 8'(int'(pr_octave) * 12 + semis(c) + 12);
      pr_len   = pr_def_len;
      pm = PM_ACC;
    end else if (c == "<") begin
      if (pr_octave > 4'd0) pr_octave = pr_octave - 4'd1;
    end else if (c == ">") begin
      if (pr_octave < 4'd15) pr_octave = pr_octave + 4'd1;
    end else if (c == "O" || c == "Q" || c == "L" || c == "T") begin
      pr_acc = 16'd0;
      pm = (c == "O") ? PM_O : (c == "Q") ? PM_Q : (c == "L") ? PM_L : PM_T;
    end else if (c == "$") begin
      pm = PM_DOLLAR;
    end else if (c == 8'd0) begin
      pr_lyric = 6'd0;
    end else begin
      halt_with(ERR_SYNTAX);
    end
  endfunction

  function automatic void close_note(input logic [7:0] c);
    if (c == "&") begin
      play_pending(1'b1);
      return;
    end
    play_pending(1'b0);
    if (!pr_halted) top_level(c);
  endfunction

  function automatic void note_length(input logic [7:0] c);
    if (is_digit(c)) begin
      pr_acc = 16'(c - "0");
      pm = PM_NUM;
    end else if (c == ".") begin
      pr_len = with_dot(pr_len);
      pm = PM_DOTS;
    end else begin
      close_note(c);
    end
  endfunction

  function automatic void skip_to_semicolon(input logic [7:0] c);
    pm = PM_SKIP;
    if (c == ";") pm = PM_TOP;
    else if (c == 8'd0) halt_with(ERR_SYNTAX);
  endfunction

  function automatic void count_lyric();
    pr_lyric = pr_lyric + 6'd1;
    if (pr_lyric > 6'(LYRIC_MAX_DEF)) halt_with(ERR_LYRIC);
  endfunction

  // Works out the result beats that one accepted text byte should cause.
  function automatic void predict_tones(input logic [7:0] c);
    int n_prior;
    tone_seg_t s;
    n_prior = expected_tones.size();
    if (pr_halted) return;
    case (pm)
      PM_TOP: top_level(c);
      PM_ACC: begin
        if (c == "+" || c == "#" || c == "-") begin
          if (!pr_rest) pr_pitch = (c == "-") ? pr_pitch - 8'd1 : pr_pitch + 8'd1;
          pm = PM_LEN;
        end else begin
          note_length(c);
        end
      end
      PM_LEN: note_length(c);
      PM_NUM: begin
        if (is_digit(c)) take_digit(c);
        else if (pr_acc == 16'd0) halt_with(ERR_ZERO);
        else begin
          pr_len = 16'(192 / int'(pr_acc));
          if (c == ".") begin
            pr_len = with_dot(pr_len);
            pm = PM_DOTS;
          end else begin
            close_note(c);
          end
        end
      end
      PM_DOTS: begin
        if (c == ".") pr_len = with_dot(pr_len);
        else close_note(c);
      end
      PM_O, PM_Q, PM_T: begin
        if (is_digit(c)) take_digit(c);
        else begin
          if (pm == PM_O) pr_octave = (pr_acc > 16'd15) ? 4'd15 : pr_acc[3:0];
          else if (pm == PM_Q) pr_gate = pr_acc;
          else pr_tempo = pr_acc;
          top_level(c);
        end
      end
      PM_L: begin
        if (is_digit(c)) take_digit(c);
        else if (pr_acc == 16'd0) halt_with(ERR_ZERO);
        else begin
          pr_def_len = 16'(192 / int'(pr_acc));
          if (c == ".") begin
            pr_def_len = with_dot(pr_def_len);
            pm = PM_LDOTS;
          end else begin
            top_level(c);
          end
        end
      end
      PM_LDOTS: begin
        if (c == ".") pr_def_len = with_dot(pr_def_len);
        else top_level(c);
      end
      PM_DOLLAR: begin
        if (c == "K") pm = PM_KSEEK;
        else skip_to_semicolon(c);
      end
      PM_SKIP: skip_to_semicolon(c);
      PM_KSEEK: begin
        if (c == "\"") begin
          pr_lyric = 6'd0;
          pm = PM_LYRIC;
        end else if (c == 8'd0) begin
          halt_with(ERR_SYNTAX);
        end
      end
      PM_LYRIC: begin
        if (c == 8'd0) halt_with(ERR_SYNTAX);
        else if (c == "\"") pm = PM_SKIP;
        else begin
          if (c == "%") pm = PM_ESC;
          count_lyric();
        end
      end
      PM_ESC: begin
        if (c == 8'd0) halt_with(ERR_SYNTAX);
        else pm = PM_LYRIC;
      end
      default: top_level(c);
    endcase
    // The final beat caused by this byte carries the end-of-run flag.
    if (expected_tones.size() > n_prior) begin
      s = expected_tones.pop_back();
      s.last = 1'b1;
      expected_tones.push_back(s);
    end
  endfunction

  // Offers one beat, waits for acceptance, and then perhaps ends the burst with a gap.
  task automatic send_byte(input logic [7:0] b);
    text_byte  <= b;
    text_valid <= 1'b1;
    do @(posedge clk); while (!text_ready);
    predict_tones(b);
    bytes_sent++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        text_valid <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 30 : 6)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_number(input int unsigned v);
    send_text($sformatf("%0d", v));
  endtask

  // Filler inside a dollar command: any byte that does not end, escape or redirect it.
  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == ";" || b == "\"" || b == "K" || b == "%");
    return b;
  endfunction

  task automatic wait_drained();
    text_valid <= 1'b0;
    while (expected_tones.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_note();
    string letters;
    int unsigned len;
    letters = "ABCDEFGR";
    send_byte(letters[$urandom_range(0, 7)]);
    case ($urandom_range(0, 4))
      0: send_byte("+");
      1: send_byte("#");
      2: send_byte("-");
      default: ;
    endcase
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 3))
        0: len = 1 << $urandom_range(0, 6);
        1: len = $urandom_range(1, 999);
        2: len = $urandom_range(1, 16);
        default: len = $urandom_range(1, 192);
      endcase
      send_number(len);
    end
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) send_byte(".");
    if ($urandom_range(0, 4) == 0) send_byte("&");
  endtask

  task automatic send_random_setting();
    case ($urandom_range(0, 5))
      0: begin
        send_byte("O");
        if ($urandom_range(0, 5) != 0) send_number($urandom_range(0, 20));
      end
      1: begin
        send_byte("Q");
        send_number(($urandom_range(0, 6) == 0) ? $urandom_range(9, 99999) : $urandom_range(0, 8));
      end
      2: begin
        send_byte("L");
        send_number(($urandom_range(0, 1) == 0) ? (1 << $urandom_range(0, 6))
                                                : $urandom_range(1, 300));
        repeat ($urandom_range(0, 2)) send_byte(".");
      end
      3: begin
        // Tempo is kept away from zero here, since a zero tempo halts the block.
        send_byte("T");
        send_number(($urandom_range(0, 7) == 0) ? $urandom_range(1000, 99999)
                                                : $urandom_range(1, 300));
      end
      4: send_byte("<");
      default: send_byte(">");
    endcase
  endtask

  task automatic send_random_dollar();
    int units;
    send_byte("$");
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(0, 5)) send_byte(filler_byte());
    end else begin
      send_byte("K");
      repeat ($urandom_range(0, 2)) send_byte(filler_byte());
      send_byte("\"");
      // The lyric stays within its limit; a percent pair counts as one character.
      units = $urandom_range(0, ($urandom_range(0, 3) == 0) ? LYRIC_MAX_DEF : 6);
      repeat (units) begin
        if ($urandom_range(0, 4) == 0) begin
          send_byte("%");
          send_byte(8'($urandom_range(1, 255)));
        end else begin
          send_byte(filler_byte());
        end
      end
      send_byte("\"");
      repeat ($urandom_range(0, 2)) send_byte(filler_byte());
    end
    send_byte(";");
  endtask

  // Extremes of octave, length, gate and tempo, accidentals, ties and dots.
  task automatic test_note_extremes();
    send_text("O0C-<CO99B+R1.&Q0E192T1A&G255T65535L8.FQ8D");
    send_byte(8'd0);
  endtask

  // Dollar commands with high filler bytes, a lyric with an escape and the end-of-text byte.
  task automatic test_dollar_commands();
    send_text("$");
    send_byte(8'hFF);
    send_text(";$K\"%\"A\";T120Q7L4C");
    send_byte(8'd0);
  endtask

  // The receiver holds off for a long stretch while notes keep coming, filling the queue.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req <= 1'b1;
    repeat (16) send_text("C16");
    send_byte("R");
    gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_text();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RAND_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: send_random_note();
        11, 12, 13, 14, 15: send_random_setting();
        16, 17: send_random_dollar();
        18: send_byte(8'd0);
        default: if ($urandom_range(0, 3) == 0) wait_drained();
      endcase
    end
    send_byte("R");
    send_byte(8'd0);
    wait_drained();
  endtask

  // Only one error can be seen per run, since the block stays halted until reset.
  task automatic test_error_halt();
    case ($urandom_range(0, 5))
      0: send_text("X");
      1: send_text("C0D");
      2: send_text("T0CD");
      3: begin
        send_text("$K\"");
        repeat (LYRIC_MAX_DEF + 1) send_byte("A");
      end
      4: begin
        send_text("$AB");
        send_byte(8'd0);
      end
      default: send_byte(8'd200);
    endcase
    send_text("CDE");
    send_byte(8'd0);
    wait_drained();
  endtask

  task automatic report(input string what);
    $display("[%0t] error: %s", $realtime, what);
    mismatches++;
  endtask

  // Result side: compare each accepted beat with the oldest expectation and drive ready.
  int stall_mode = 0;
  int stall_age = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    tone_seg_t want;
    if (rst) begin
      tone_ready <= 1'b0;
    end else begin
      if (tone_valid && tone_ready) begin
        tones_seen++;
        if (expected_tones.size() == 0) begin
          report($sformatf("unexpected result tone %0d dur %0d err %0d",
                           tone_mhz, duration_ticks, error_code));
        end else begin
          want = expected_tones.pop_front();
          if (tone_mhz !== want.tone)
            report($sformatf("tone_mhz %0d, wanted %0d", tone_mhz, want.tone));
          if (duration_ticks !== want.dur)
            report($sformatf("duration_ticks %0d, wanted %0d", duration_ticks, want.dur));
          if (error_code !== want.err)
            report($sformatf("error_code %0d, wanted %0d", error_code, want.err));
          if (last_of_run !== want.last)
            report($sformatf("last_of_run %0d, wanted %0d", last_of_run, want.last));
        end
      end
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req <= 1'b0;
      end
      stall_age++;
      if (stall_age >= 64) begin
        stall_age = 0;
        stall_mode = $urandom_range(0, 2);
      end
      if (hold_left > 0) begin
        hold_left--;
        tone_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: tone_ready <= 1'b1;
          1: tone_ready <= ($urandom_range(0, 3) != 0);
          default: tone_ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // Watchdog: too long without any beat on either channel means the block has hung.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((text_valid && text_ready) || (tone_valid && tone_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_tones.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    pm = PM_TOP;
    pr_octave = 4'd4;
    pr_def_len = 16'd48;
    pr_gate = 16'd7;
    pr_tempo = 16'd120;
    pr_acc = 16'd0;
    pr_pitch = 8'd0;
    pr_rest = 1'b0;
    pr_len = 16'd0;
    pr_lyric = 6'd0;
    pr_halted = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_note_extremes();
    test_dollar_commands();
    test_backpressure();
    test_random_text();
    test_error_halt();

    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d text bytes and checked %0d tone beats, including a long receiver hold,",
             bytes_sent, tones_seen);
    $display("drain pauses, dollar commands, lyrics and a final error with halt.");
    if (mismatches == 0 && expected_tones.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, expected_tones.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
